### src/bgsa_pkg.sv
// Shared types and constants for the binned genotype score accumulator.
// Used by the controller, the datapath and the top level; depends on nothing.
package bgsa_pkg;

   // Operation codes carried in the request tuser field.
   localparam logic [1:0] OP_PACKED  = 2'd0;
   localparam logic [1:0] OP_SELECT  = 2'd1;
   localparam logic [1:0] OP_READOUT = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   localparam int OPCODE_W      = 2;
   localparam int GENO_W        = 8;
   localparam int OFFSET_W      = 2;
   localparam int COUNT_W       = 3;
   localparam int SAMPLE_W      = 12;
   localparam int BIN_W         = 4;
   localparam int WEIGHT_W      = 32;
   localparam int SCORE_W       = 48;
   localparam int BINS_CFG_W    = 5;
   localparam int STEP_W        = 4;
   localparam int CODES_PER_BYTE = 4;

   // Wide enough for any sample number plus three against any store size.
   localparam int SAMPLE_CALC_W = 21;
   // Wide enough for a bin address of the largest store.
   localparam int BIN_CALC_W    = 6;

   // Request tdata layout, lowest field first.
   localparam int GENO_LSB      = 0;
   localparam int OFFSET_LSB    = GENO_LSB + GENO_W;
   localparam int COUNT_LSB     = OFFSET_LSB + OFFSET_W;
   localparam int SAMPLE_LSB    = COUNT_LSB + COUNT_W;
   localparam int BIN_LSB       = SAMPLE_LSB + SAMPLE_W;
   localparam int WEIGHT_LSB    = BIN_LSB + BIN_W;
   localparam int REQ_TDATA_W   = 64;

   // Result tdata layout: bin_index, then score, zero padded.
   localparam int RSP_TDATA_W   = 56;
   localparam int RSP_PAD_W     = RSP_TDATA_W - BIN_W - SCORE_W;

   localparam logic [BINS_CFG_W-1:0] BINS_USED_RESET = 5'd16;
   localparam logic [BINS_CFG_W-1:0] BINS_HW_LIMIT   = 5'd16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load;
      logic              clear;
      logic              acc_read;
      logic              ro_read;
      logic              last_step;
      logic [STEP_W-1:0] step;
   } bgsa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic            clear_done;
      logic            out_free;
      logic            is_readout;
      logic [STEP_W:0] steps;
   } bgsa_status_type;

endpackage

### src/bgsa_ctrl.sv
// Controller state machine for the binned genotype score accumulator.
// Sequences the clearing pass, accumulate codes and read-out bins; uses bgsa_pkg.
module bgsa_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  bgsa_pkg::bgsa_status_type st_i,
   output bgsa_pkg::bgsa_cmd_type    cmd_o
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_ACC   = 2'd2;
   localparam logic [1:0] ST_RO    = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [bgsa_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic [bgsa_pkg::STEP_W-1:0] last_ff, last_in;
   logic [bgsa_pkg::STEP_W:0]   steps_m1;

   assign steps_m1   = st_i.steps - (bgsa_pkg::STEP_W+1)'(1);
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      last_in         = last_ff;
      cmd_o.load      = 1'b0;
      cmd_o.clear     = 1'b0;
      cmd_o.acc_read  = 1'b0;
      cmd_o.ro_read   = 1'b0;
      cmd_o.step      = cnt_ff;
      cmd_o.last_step = (cnt_ff == last_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            cmd_o.clear = 1'b1;
            if (st_i.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd_o.load = req_tvalid;
            // An item with nothing to do is simply absorbed here.
            if (req_tvalid && (st_i.steps != '0)) begin
               cnt_in   = '0;
               last_in  = steps_m1[bgsa_pkg::STEP_W-1:0];
               state_in = st_i.is_readout ? ST_RO : ST_ACC;
            end
         end
         ST_ACC: begin
            cmd_o.acc_read = 1'b1;
            cnt_in         = cnt_ff + bgsa_pkg::STEP_W'(1);
            if (cmd_o.last_step) begin
               state_in = ST_IDLE;
            end
         end
         ST_RO: begin
            if (st_i.out_free) begin
               cmd_o.ro_read = 1'b1;
               cnt_in        = cnt_ff + bgsa_pkg::STEP_W'(1);
               if (cmd_o.last_step) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

   // The step counter never runs past the final step of an item.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ACC) || (state_ff == ST_RO)) |-> (cnt_ff <= last_ff))
      else $error("step counter beyond last step");

   // A read-out bin is only started when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd_o.ro_read |-> st_i.out_free)
      else $error("read-out issued while output register busy");

   // After the final code of an item the input side opens again.
   assert property (@(posedge clock) disable iff (reset)
      (cmd_o.acc_read && cmd_o.last_step) |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after last code");

endmodule

### src/bgsa_datapath.sv
// Datapath of the binned genotype score accumulator: item registers, score store,
// saturating adders, running total and result register. Uses bgsa_pkg.
module bgsa_datapath #(
   parameter int SAMPLES = 4096,
   parameter int BINS    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [bgsa_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [bgsa_pkg::OPCODE_W-1:0]        req_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bgsa_pkg::BINS_CFG_W-1:0]      csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bgsa_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,
   input  bgsa_pkg::bgsa_cmd_type               cmd_i,
   output bgsa_pkg::bgsa_status_type            st_o
);

   localparam int SW    = $clog2(SAMPLES);
   localparam int BW    = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int AW    = SW + BW;
   localparam int DEPTH = 2 ** AW;
   localparam logic [bgsa_pkg::BINS_CFG_W-1:0] BIN_LIMIT =
      (BINS < 16) ? bgsa_pkg::BINS_CFG_W'(BINS) : bgsa_pkg::BINS_HW_LIMIT;
   localparam logic [bgsa_pkg::SAMPLE_CALC_W-1:0] SAMPLE_LIMIT =
      bgsa_pkg::SAMPLE_CALC_W'(SAMPLES);

   function automatic logic [bgsa_pkg::SCORE_W-1:0] sat48(
      input logic [bgsa_pkg::SCORE_W:0] sum
   );
      logic [bgsa_pkg::SCORE_W-1:0] res;
      if (sum[bgsa_pkg::SCORE_W] != sum[bgsa_pkg::SCORE_W-1]) begin
         res = sum[bgsa_pkg::SCORE_W] ? {1'b1, {(bgsa_pkg::SCORE_W-1){1'b0}}}
                                      : {1'b0, {(bgsa_pkg::SCORE_W-1){1'b1}}};
      end else begin
         res = sum[bgsa_pkg::SCORE_W-1:0];
      end
      return res;
   endfunction

   // Configuration.
   logic [bgsa_pkg::BINS_CFG_W-1:0] bins_used_ff;
   logic [bgsa_pkg::BINS_CFG_W-1:0] nb;

   // Incoming item decode.
   logic [bgsa_pkg::COUNT_W-1:0]       req_count;
   logic [bgsa_pkg::COUNT_W-1:0]       req_count_cl;
   logic [bgsa_pkg::SAMPLE_W-1:0]      req_sample;
   logic [bgsa_pkg::BIN_W-1:0]         req_bin;
   logic                               req_bin_ok;
   logic                               req_row_ok;

   // Item registers.
   logic [bgsa_pkg::OPCODE_W-1:0]      opcode_ff;
   logic [bgsa_pkg::GENO_W-1:0]        geno_ff;
   logic [bgsa_pkg::OFFSET_W-1:0]      offset_ff;
   logic [bgsa_pkg::SAMPLE_W-1:0]      sample_ff;
   logic [bgsa_pkg::BIN_W-1:0]         bin_ff;
   logic signed [bgsa_pkg::WEIGHT_W-1:0] weight_ff;

   // Read address path.
   logic [bgsa_pkg::SAMPLE_CALC_W-1:0] sample_k;
   logic [bgsa_pkg::BIN_CALC_W-1:0]    bin_sel;
   logic [1:0]                         code_idx;
   logic [bgsa_pkg::GENO_W-1:0]        geno_shift;
   logic [1:0]                         code;
   logic                               contrib;
   logic [AW-1:0]                      raddr;

   // Store and pending write.
   logic [bgsa_pkg::SCORE_W-1:0]       score_mem [DEPTH];
   logic [bgsa_pkg::SCORE_W-1:0]       rdata_ff;
   logic                               pend_acc_ff;
   logic                               pend_ro_ff;
   logic [AW-1:0]                      pend_addr_ff;
   logic                               pend_dbl_ff;
   logic                               pend_first_ff;
   logic                               pend_last_ff;
   logic [bgsa_pkg::BIN_W-1:0]         pend_bin_ff;
   logic [AW-1:0]                      clr_addr_ff, clr_addr_in;
   logic                               we;
   logic [AW-1:0]                      waddr;
   logic [bgsa_pkg::SCORE_W-1:0]       wdata;
   logic [bgsa_pkg::SCORE_W:0]         addend;
   logic [bgsa_pkg::SCORE_W:0]         acc_sum;
   logic [bgsa_pkg::SCORE_W:0]         ro_base;
   logic [bgsa_pkg::SCORE_W:0]         ro_sum;
   logic [bgsa_pkg::SCORE_W-1:0]       ro_total;

   // Running total and result register.
   logic [bgsa_pkg::SCORE_W-1:0]       total_ff;
   logic                               out_valid_ff, out_valid_in;
   logic [bgsa_pkg::SCORE_W-1:0]       out_score_ff;
   logic [bgsa_pkg::BIN_W-1:0]         out_bin_ff;
   logic                               out_last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_used_ff <= bgsa_pkg::BINS_USED_RESET;
      end else if (csr_valid && csr_ready) begin
         bins_used_ff <= csr_wdata;
      end
   end

   // Zero acts as one bin; anything above BINS, or above 16, is clamped.
   always_comb begin
      if (bins_used_ff == '0) begin
         nb = bgsa_pkg::BINS_CFG_W'(1);
      end else if (bins_used_ff > BIN_LIMIT) begin
         nb = BIN_LIMIT;
      end else begin
         nb = bins_used_ff;
      end
   end

   assign req_count  = req_tdata[bgsa_pkg::COUNT_LSB +: bgsa_pkg::COUNT_W];
   assign req_sample = req_tdata[bgsa_pkg::SAMPLE_LSB +: bgsa_pkg::SAMPLE_W];
   assign req_bin    = req_tdata[bgsa_pkg::BIN_LSB +: bgsa_pkg::BIN_W];
   assign req_count_cl = (req_count > bgsa_pkg::COUNT_W'(bgsa_pkg::CODES_PER_BYTE))
                       ? bgsa_pkg::COUNT_W'(bgsa_pkg::CODES_PER_BYTE) : req_count;
   assign req_bin_ok = (bgsa_pkg::BINS_CFG_W'(req_bin) < nb);
   assign req_row_ok = (bgsa_pkg::SAMPLE_CALC_W'(req_sample) < SAMPLE_LIMIT);

   always_comb begin
      st_o.is_readout = (req_tuser == bgsa_pkg::OP_READOUT);
      st_o.clear_done = (clr_addr_ff == '1);
      st_o.out_free   = (!out_valid_ff || rsp_tready) && !pend_ro_ff;
      unique case (req_tuser)
         bgsa_pkg::OP_PACKED:
            st_o.steps = req_bin_ok ? (bgsa_pkg::STEP_W+1)'(req_count_cl) : '0;
         bgsa_pkg::OP_SELECT:
            st_o.steps = req_bin_ok ? (bgsa_pkg::STEP_W+1)'(1) : '0;
         bgsa_pkg::OP_READOUT:
            st_o.steps = req_row_ok ? nb : '0;
         bgsa_pkg::OP_NONE:
            st_o.steps = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         opcode_ff <= req_tuser;
         geno_ff   <= req_tdata[bgsa_pkg::GENO_LSB +: bgsa_pkg::GENO_W];
         offset_ff <= req_tdata[bgsa_pkg::OFFSET_LSB +: bgsa_pkg::OFFSET_W];
         sample_ff <= req_sample;
         bin_ff    <= req_bin;
         weight_ff <= req_tdata[bgsa_pkg::WEIGHT_LSB +: bgsa_pkg::WEIGHT_W];
      end
   end

   // Packed items walk consecutive samples; the other kinds stay on one sample.
   always_comb begin
      if (opcode_ff == bgsa_pkg::OP_PACKED) begin
         sample_k = bgsa_pkg::SAMPLE_CALC_W'(sample_ff)
                  + bgsa_pkg::SAMPLE_CALC_W'(cmd_i.step);
      end else begin
         sample_k = bgsa_pkg::SAMPLE_CALC_W'(sample_ff);
      end
      bin_sel    = (opcode_ff == bgsa_pkg::OP_READOUT) ? bgsa_pkg::BIN_CALC_W'(cmd_i.step)
                                                       : bgsa_pkg::BIN_CALC_W'(bin_ff);
      code_idx   = (opcode_ff == bgsa_pkg::OP_SELECT) ? offset_ff : cmd_i.step[1:0];
      geno_shift = geno_ff >> {code_idx, 1'b0};
      code       = geno_shift[1:0];
      // Codes with the low bit set (missing or homozygous alternate) add nothing.
      contrib    = (sample_k < SAMPLE_LIMIT) && !code[0];
      raddr      = {sample_k[SW-1:0], bin_sel[BW-1:0]};
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd_i.clear) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         pend_acc_ff <= 1'b0;
         pend_ro_ff  <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         pend_acc_ff <= cmd_i.acc_read && contrib;
         pend_ro_ff  <= cmd_i.ro_read;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff  <= raddr;
      pend_dbl_ff   <= !code[1];
      pend_first_ff <= (cmd_i.step == '0);
      pend_last_ff  <= cmd_i.last_step;
      pend_bin_ff   <= cmd_i.step;
   end

   // Dosage is one or two, so the product is the weight or the weight doubled.
   assign addend  = pend_dbl_ff
                  ? {{(bgsa_pkg::SCORE_W-bgsa_pkg::WEIGHT_W){weight_ff[bgsa_pkg::WEIGHT_W-1]}},
                     weight_ff, 1'b0}
                  : {{(bgsa_pkg::SCORE_W-bgsa_pkg::WEIGHT_W+1){weight_ff[bgsa_pkg::WEIGHT_W-1]}},
                     weight_ff};
   assign acc_sum = {rdata_ff[bgsa_pkg::SCORE_W-1], rdata_ff} + addend;
   assign ro_base = pend_first_ff ? '0 : {total_ff[bgsa_pkg::SCORE_W-1], total_ff};
   assign ro_sum  = ro_base + {rdata_ff[bgsa_pkg::SCORE_W-1], rdata_ff};
   assign ro_total = sat48(ro_sum);

   always_comb begin
      we    = 1'b0;
      waddr = pend_addr_ff;
      wdata = '0;
      priority if (cmd_i.clear) begin
         we    = 1'b1;
         waddr = clr_addr_ff;
      end else if (pend_acc_ff) begin
         we    = 1'b1;
         wdata = sat48(acc_sum);
      end else if (pend_ro_ff) begin
         // Read-out clears the entry it has just consumed.
         we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         score_mem[waddr] <= wdata;
      end
      rdata_ff <= score_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (pend_ro_ff) begin
         total_ff     <= ro_total;
         out_score_ff <= ro_total;
         out_bin_ff   <= pend_bin_ff;
         out_last_ff  <= pend_last_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pend_ro_ff) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{bgsa_pkg::RSP_PAD_W{1'b0}}, out_score_ff, out_bin_ff};

   // A read-out bin only lands in an empty output register.
   assert property (@(posedge clock) disable iff (reset)
      pend_ro_ff |-> !out_valid_ff)
      else $error("read-out result would overwrite a waiting item");

   // The single write port never serves an accumulate and a read-out together.
   assert property (@(posedge clock) disable iff (reset)
      !(pend_acc_ff && pend_ro_ff))
      else $error("accumulate and read-out writes collide");

   // The clearing pass owns the write port alone.
   assert property (@(posedge clock) disable iff (reset)
      cmd_i.clear |-> (!pend_acc_ff && !pend_ro_ff))
      else $error("store write pending during clearing pass");

endmodule

### src/binned_genotype_score_accumulator.sv
// Top level of the binned genotype score accumulator.
// Joins bgsa_ctrl and bgsa_datapath; uses bgsa_pkg.
//
// After reset the block clears every entry of its score store, one entry per
// cycle; req_tready stays low meanwhile, while csr writes are taken at any time.
// The store is a single memory of saturating Q24.24 accumulators addressed by
// sample and bin, updated by read-modify-write, and that memory sets the rate:
// an accumulate item reads one code's entry per cycle, min(code_count, 4) codes
// for a packed item and one for a selected item, and req_tready stays low until
// its last code is read. A read-out item returns one result per bin in use, in
// bin order, starting each bin only when the output register is free to take its
// result, and clears the row as it goes. Items that change nothing (bin not in
// use, read-out of a row beyond the store, zero code count, unused opcode) are
// taken without leaving idle. Results wait in an output register, so a new item
// can be accepted while the last result is unread.
module binned_genotype_score_accumulator #(
   parameter int SAMPLES = 4096,
   parameter int BINS    = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata from bit 0: geno_byte[7:0], code_offset[9:8], code_count[12:10],
   // sample_index[24:13], bin[28:25], weight[60:29], zero fill [63:61].
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bgsa_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: opcode[1:0].
   input  logic [bgsa_pkg::OPCODE_W-1:0]    req_tuser,
   // rsp_tdata from bit 0: bin_index[3:0], score[51:4], zero fill [55:52].
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bgsa_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast,
   // csr_wdata: bins_used[4:0].
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bgsa_pkg::BINS_CFG_W-1:0]  csr_wdata
);

   bgsa_pkg::bgsa_cmd_type    cmd;
   bgsa_pkg::bgsa_status_type st;

   bgsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st_i       (st),
      .cmd_o      (cmd)
   );

   bgsa_datapath #(
      .SAMPLES (SAMPLES),
      .BINS    (BINS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd_i      (cmd),
      .st_o       (st)
   );

endmodule
